// ----- hdl/dht_pkg.sv -----
// dht_pkg: shared types and constants for the double hashing table.
// No dependencies; used by every file of the block.
package dht_pkg;

  localparam int KEY_W      = 31;
  localparam int VAL_W      = 32;
  localparam int HASH_PRIME = 7;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_SEARCH = 2'd1;
  localparam logic [1:0] KIND_REMOVE = 2'd2;

  localparam logic [1:0] STATUS_DONE      = 2'd0;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STATUS_FULL      = 2'd2;

  localparam logic [1:0] MARK_EMPTY   = 2'd0;
  localparam logic [1:0] MARK_USED    = 2'd1;
  localparam logic [1:0] MARK_DELETED = 2'd2;

  typedef struct packed {
    logic       capture;
    logic       load_base;
    logic       advance;
    logic       count;
    logic       wr_entry;
    logic       wr_del;
    logic       clr_write;
    logic       set_res;
    logic [1:0] res_status;
    logic       res_take_val;
    logic       load_out;
  } dht_cmd_t;

  typedef struct packed {
    logic       hash_done;
    logic [1:0] kind;
    logic [1:0] mark;
    logic       key_match;
    logic       last;
  } dht_sts_t;

endpackage

// ----- hdl/dht_req_if.sv -----
// dht_req_if: request channel (operation, key, value) with valid/ready.
// Depends on dht_pkg for field widths.
interface dht_req_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      kind;
  logic [dht_pkg::KEY_W-1:0]       key;
  logic signed [dht_pkg::VAL_W-1:0] entry_value;

  modport source (output valid, kind, key, entry_value, input ready);
  modport sink   (input valid, kind, key, entry_value, output ready);
endinterface

// ----- hdl/dht_rsp_if.sv -----
// dht_rsp_if: response channel (status, found value) with valid/ready.
// Depends on dht_pkg for field widths.
interface dht_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       status;
  logic signed [dht_pkg::VAL_W-1:0] found_value;

  modport source (output valid, status, found_value, input ready);
  modport sink   (input valid, status, found_value, output ready);
endinterface

// ----- hdl/dht_hash.sv -----
// dht_hash: serial residue unit, key mod TABLE_SIZE and key mod 7,
// four key bits per cycle. Depends on dht_pkg.
module dht_hash #(
  parameter int TABLE_SIZE = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [dht_pkg::KEY_W-1:0]       key,
  output logic                            done,
  output logic [$clog2(TABLE_SIZE)-1:0]   base,
  output logic [2:0]                      step
);
  import dht_pkg::*;

  localparam int IW    = $clog2(TABLE_SIZE);
  localparam int DIG   = 4;
  localparam int NSTEP = (KEY_W + DIG - 1) / DIG;
  localparam int PW    = NSTEP * DIG;
  localparam int CW    = $clog2(NSTEP);
  localparam logic [IW:0] SIZE_C  = (IW+1)'(TABLE_SIZE);
  localparam logic [3:0]  PRIME_C = 4'(HASH_PRIME);

  logic [PW-1:0] sh;
  logic [IW-1:0] rn, rn_next;
  logic [2:0]    r7, r7_next;
  logic [CW-1:0] cnt;
  logic          busy;

  always_comb begin
    logic [IW:0] tn;
    logic [3:0]  t7;
    tn = {1'b0, rn};
    t7 = {1'b0, r7};
    for (int b = 0; b < DIG; b++) begin
      tn = {tn[IW-1:0], sh[PW-1-b]};
      if (tn >= SIZE_C) tn = tn - SIZE_C;
      t7 = {t7[2:0], sh[PW-1-b]};
      if (t7 >= PRIME_C) t7 = t7 - PRIME_C;
    end
    rn_next = tn[IW-1:0];
    r7_next = t7[2:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        sh   <= {{(PW-KEY_W){1'b0}}, key};
        rn   <= '0;
        r7   <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        sh  <= sh << DIG;
        rn  <= rn_next;
        r7  <= r7_next;
        cnt <= cnt + 1'b1;
        if (cnt == CW'(NSTEP-1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign base = rn;
  assign step = 3'(HASH_PRIME) - r7;

endmodule

// ----- hdl/dht_datapath.sv -----
// dht_datapath: slot memories, probe index walk, result and output registers.
// Depends on dht_pkg and dht_hash.
module dht_datapath #(
  parameter int TABLE_SIZE = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  dht_pkg::dht_cmd_t                cmd,
  output dht_pkg::dht_sts_t                sts,
  input  logic [1:0]                       in_kind,
  input  logic [dht_pkg::KEY_W-1:0]        in_key,
  input  logic signed [dht_pkg::VAL_W-1:0] in_value,
  output logic [1:0]                       out_status,
  output logic signed [dht_pkg::VAL_W-1:0] out_found
);
  import dht_pkg::*;

  localparam int IW = $clog2(TABLE_SIZE);
  localparam logic [IW:0] SIZE_C = (IW+1)'(TABLE_SIZE);

  logic [KEY_W-1:0] slot_keys   [TABLE_SIZE];
  logic [VAL_W-1:0] slot_values [TABLE_SIZE];
  logic [1:0]       slot_marks  [TABLE_SIZE];

  logic [1:0]       kind_r;
  logic [KEY_W-1:0] key_r;
  logic [VAL_W-1:0] val_r;
  logic [IW-1:0]    idx, idx_next, att, rd_idx, wr_addr, base;
  logic [2:0]       step, step_r;
  logic [IW:0]      sum;
  logic [KEY_W-1:0] rd_key;
  logic [VAL_W-1:0] rd_val;
  logic [1:0]       rd_mark, wr_mark;
  logic [1:0]       res_status;
  logic [VAL_W-1:0] res_found;
  logic             hash_done;

  dht_hash #(.TABLE_SIZE(TABLE_SIZE)) u_hash (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.capture),
    .key  (in_key),
    .done (hash_done),
    .base (base),
    .step (step)
  );

  // step is below 8; with at least 8 slots (not enforced here) one subtract wraps
  always_comb begin
    sum      = {1'b0, idx} + {{(IW-2){1'b0}}, step_r};
    if (sum >= SIZE_C) sum = sum - SIZE_C;
    idx_next = sum[IW-1:0];
  end

  assign wr_addr = cmd.clr_write ? att : rd_idx;

  always_comb begin
    if (cmd.clr_write)   wr_mark = MARK_EMPTY;
    else if (cmd.wr_del) wr_mark = MARK_DELETED;
    else                 wr_mark = MARK_USED;
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_entry) begin
      slot_keys[rd_idx]   <= key_r;
      slot_values[rd_idx] <= val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_entry || cmd.wr_del || cmd.clr_write) begin
      slot_marks[wr_addr] <= wr_mark;
    end
  end

  always_ff @(posedge clk) begin
    rd_key  <= slot_keys[idx];
    rd_val  <= slot_values[idx];
    rd_mark <= slot_marks[idx];
    rd_idx  <= idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      att <= '0;
    end else begin
      if (cmd.load_base) begin
        att <= '0;
      end else if (cmd.count || cmd.clr_write) begin
        att <= att + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r <= in_kind;
      key_r  <= in_key;
      val_r  <= in_value;
    end
    if (cmd.load_base) begin
      idx    <= base;
      step_r <= step;
    end else if (cmd.advance) begin
      idx <= idx_next;
    end
    if (cmd.set_res) begin
      res_status <= cmd.res_status;
      res_found  <= cmd.res_take_val ? rd_val : '0;
    end
    if (cmd.load_out) begin
      out_status <= res_status;
      out_found  <= res_found;
    end
  end

  assign sts.hash_done = hash_done;
  assign sts.kind      = kind_r;
  assign sts.mark      = rd_mark;
  assign sts.key_match = (rd_key == key_r);
  assign sts.last      = (att == IW'(TABLE_SIZE-1));

endmodule

// ----- hdl/dht_ctrl.sv -----
// dht_ctrl: operation sequencer (clear, hash, probe, respond).
// Depends on dht_pkg; drives dht_datapath through dht_cmd_t.
module dht_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  input  dht_pkg::dht_sts_t sts,
  output dht_pkg::dht_cmd_t cmd
);
  import dht_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_HASH, ST_FETCH, ST_CHECK, ST_EMIT
  } state_t;

  state_t state, state_next;
  logic   finish;

  assign req_ready = (state == ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    finish     = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clr_write = 1'b1;
        if (sts.last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_HASH;
        end
      end
      ST_HASH: begin
        if (sts.hash_done) begin
          cmd.load_base = 1'b1;
          state_next    = ST_FETCH;
        end
      end
      ST_FETCH: begin
        cmd.advance = 1'b1;
        state_next  = ST_CHECK;
      end
      ST_CHECK: begin
        unique case (sts.kind)
          KIND_INSERT: begin
            if (sts.mark != MARK_USED) begin
              cmd.wr_entry   = 1'b1;
              cmd.res_status = STATUS_DONE;
              finish         = 1'b1;
            end else if (sts.last) begin
              cmd.res_status = STATUS_FULL;
              finish         = 1'b1;
            end
          end
          KIND_SEARCH, KIND_REMOVE: begin
            if (sts.mark == MARK_EMPTY) begin
              cmd.res_status = STATUS_NOT_FOUND;
              finish         = 1'b1;
            end else if (sts.mark == MARK_USED && sts.key_match) begin
              cmd.wr_del       = (sts.kind == KIND_REMOVE);
              cmd.res_take_val = (sts.kind == KIND_SEARCH);
              cmd.res_status   = STATUS_DONE;
              finish           = 1'b1;
            end else if (sts.last) begin
              cmd.res_status = STATUS_NOT_FOUND;
              finish         = 1'b1;
            end
          end
          default: begin
            cmd.res_status = STATUS_NOT_FOUND;
            finish         = 1'b1;
          end
        endcase
        if (finish) begin
          cmd.set_res = 1'b1;
          state_next  = ST_EMIT;
        end else begin
          cmd.advance = 1'b1;
          cmd.count   = 1'b1;
        end
      end
      ST_EMIT: begin
        if (!rsp_valid || rsp_ready) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
    end
  end

endmodule

// ----- hdl/double_hash_table_core.sv -----
// Channel | Dir | Fields                   | Handshake
// req     | in  | kind, key, entry_value   | valid/ready
// rsp     | out | status, found_value      | valid/ready
//
// One operation at a time: accept, hash, fetch, 1..TABLE_SIZE probes and
// respond, in that order; the serial hash and the one-slot-per-cycle probe
// walk over the slot memories set how long an operation takes.
// After reset a clearing pass sets every slot mark to empty; req.ready is low.
// A response waiting on rsp does not block the next request from being taken.
// Top level of the double hashing key-value table; uses dht_pkg, dht_ctrl,
// dht_datapath and the dht_req_if / dht_rsp_if channels.
module double_hash_table_core #(
  parameter int TABLE_SIZE = 16
) (
  input logic       clk,
  input logic       rst,
  dht_req_if.sink   req,
  dht_rsp_if.source rsp
);
  import dht_pkg::*;

  dht_cmd_t cmd;
  dht_sts_t sts;

  dht_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req.valid),
    .req_ready(req.ready),
    .rsp_valid(rsp.valid),
    .rsp_ready(rsp.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dht_datapath #(.TABLE_SIZE(TABLE_SIZE)) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_kind   (req.kind),
    .in_key    (req.key),
    .in_value  (req.entry_value),
    .out_status(rsp.status),
    .out_found (rsp.found_value)
  );

endmodule

// ----- hdl/dht_checker.sv -----
// dht_checker: port-level assertions for double_hash_table_core, bound below.
// Depends on dht_pkg.
module dht_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             req_valid,
  input logic                             req_ready,
  input logic                             rsp_valid,
  input logic                             rsp_ready,
  input logic [1:0]                       rsp_status,
  input logic signed [dht_pkg::VAL_W-1:0] found_value
);
  import dht_pkg::*;

  // clearing pass follows reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !req_ready && !rsp_valid)
    else $error("ready or valid high right after reset");

  // one item in flight
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("second item taken while busy");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(found_value))
    else $error("stalled item changed");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_status == STATUS_DONE || rsp_status == STATUS_NOT_FOUND ||
                   rsp_status == STATUS_FULL))
    else $error("bad status code");

  a_value_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != STATUS_DONE |-> found_value == '0)
    else $error("nonzero value on miss or full");

endmodule

bind double_hash_table_core dht_checker u_dht_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_status (rsp.status),
  .found_value(rsp.found_value)
);
